### src/phist_pkg.sv
// shared types and constants of the pc sample histogram
package phist_pkg;

	// controller states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// input command codes
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_SAMPLE  = 2'd0;
	localparam cmd_t CMD_READ    = 2'd1;
	localparam cmd_t CMD_RESTART = 2'd2;

	// configuration register indexes
	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_WINDOW_LENGTH = 1'd0;
	localparam reg_idx_t REG_BIN_SHIFT     = 1'd1;

	localparam int unsigned CFG_DATA_W = 32;
	localparam logic [31:0] WINDOW_LENGTH_RST = 32'd600000;
	localparam logic [4:0]  BIN_SHIFT_RST     = 5'd6;

	// commands from controller to datapath
	typedef struct packed {
		logic clear_en;
		logic capture;
		logic exec;
	} ctrl_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic clear_done;
	} dp_status_t;

endpackage

### src/phist_ctrl.sv
// controller state machine of the pc sample histogram
module phist_ctrl
	import phist_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  logic       out_stall,
	input  dp_status_t status,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	// output register can take a new result
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.clear_en = 1'b0;
		cmd.capture  = 1'b0;
		cmd.exec     = 1'b0;
		in_stall     = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
				if (status.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// an input transfer always leads to the update state
	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_EXEC))
		else $error("input transfer did not enter update state");

	// an update always leaves a result waiting
	a_exec_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> out_valid_q)
		else $error("update did not present a result");

	// a held result keeps the next item waiting
	a_hold_while_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && out_stall) |=> (state_q == ST_EXEC))
		else $error("item updated while result was still held");

endmodule

### src/phist_dp.sv
// datapath of the pc sample histogram: bin memory, window state and result register
module phist_dp
	import phist_pkg::*;
#(
	parameter int unsigned BIN_COUNT   = 512,
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	output dp_status_t            status,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  cmd_t                  command,
	input  logic [31:0]           pc_value,
	input  logic [31:0]           now_tick,
	input  logic [8:0]            bin_select,
	output logic [31:0]           bin_count,
	output logic                  sample_counted,
	output logic                  window_closed,
	output logic                  collecting_now,
	output logic [31:0]           windows_done
);

	localparam int unsigned BIN_W = $clog2(BIN_COUNT);

	logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];

	logic [31:0]            window_length_q;
	logic [4:0]             bin_shift_q;
	logic [BIN_W-1:0]       clr_addr_q;
	cmd_t                   cmd_q;
	logic [BIN_W-1:0]       addr_q;
	logic                   in_range_q;
	logic [31:0]            now_q;
	logic [COUNT_WIDTH-1:0] rd_data_q;
	logic [31:0]            stop_tick_q;
	logic                   collecting_q;
	logic [31:0]            window_count_q;

	logic [31:0]            bin_full;
	logic [31:0]            sel_full;
	logic [31:0]            rd_full;
	logic                   rd_in_range;
	logic [63:0]            rd_wide;
	logic                   wr_en;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic [31:0]            count_d;
	logic                   counted_d;
	logic                   closed_d;
	logic                   collecting_d;
	logic [31:0]            stop_d;
	logic [31:0]            window_count_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_length_q <= WINDOW_LENGTH_RST;
			bin_shift_q     <= BIN_SHIFT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_LENGTH: window_length_q <= cfg_data[31:0];
				REG_BIN_SHIFT:     bin_shift_q     <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// clearing sweep over the bins after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_en) begin
			clr_addr_q <= clr_addr_q + BIN_W'(1);
		end
	end
	assign status.clear_done = (clr_addr_q == BIN_W'(BIN_COUNT - 1));

	// bin address of the incoming item
	assign bin_full    = pc_value >> bin_shift_q;
	assign sel_full    = 32'(bin_select);
	assign rd_full     = (command == CMD_READ) ? sel_full : bin_full;
	assign rd_in_range = (rd_full < 32'(BIN_COUNT));

	// item capture and registered bin read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q      <= command;
			addr_q     <= rd_full[BIN_W-1:0];
			in_range_q <= rd_in_range;
			now_q      <= now_tick;
			rd_data_q  <= mem[rd_full[BIN_W-1:0]];
		end
	end

	// per-command update
	assign rd_wide = 64'(rd_data_q);
	always_comb begin
		wr_en          = 1'b0;
		wr_data        = '0;
		count_d        = '0;
		counted_d      = 1'b0;
		closed_d       = 1'b0;
		collecting_d   = collecting_q;
		stop_d         = stop_tick_q;
		window_count_d = window_count_q;
		unique case (cmd_q)
			CMD_SAMPLE: begin
				if (collecting_q) begin
					if (in_range_q) begin
						wr_en     = 1'b1;
						wr_data   = rd_data_q + COUNT_WIDTH'(1);
						counted_d = 1'b1;
					end
					if (now_q > stop_tick_q) begin
						collecting_d = 1'b0;
						closed_d     = 1'b1;
					end
				end
			end
			CMD_READ: begin
				if (in_range_q) begin
					wr_en   = 1'b1;
					count_d = rd_wide[31:0];
				end
			end
			CMD_RESTART: begin
				stop_d         = now_q + window_length_q;
				collecting_d   = 1'b1;
				window_count_d = window_count_q + 32'd1;
			end
			default: ;
		endcase
	end

	// bin memory write port
	always_ff @(posedge clk) begin
		if (cmd.clear_en) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.exec && wr_en) begin
			mem[addr_q] <= wr_data;
		end
	end

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_tick_q    <= '0;
			collecting_q   <= 1'b0;
			window_count_q <= '0;
		end else if (cmd.exec) begin
			stop_tick_q    <= stop_d;
			collecting_q   <= collecting_d;
			window_count_q <= window_count_d;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			bin_count      <= count_d;
			sample_counted <= counted_d;
			window_closed  <= closed_d;
			collecting_now <= collecting_d;
			windows_done   <= window_count_d;
		end
	end

endmodule

### src/pc_sample_histogram.sv
// Program counter sampling histogram, top level.
//
// Input channel (in_valid / in_stall): command, pc_value, now_tick and
// bin_select; a transfer happens when in_valid is high and in_stall low.
// Commands: sample a pc into its bin while a window is open, read and
// clear one bin, or restart the collection window.
// Output channel (out_valid / out_stall): one result per input item,
// held in an output register until the receiver takes it.
// Configuration: cfg_we, cfg_index and cfg_data write window_length
// (index 0) and bin_shift (index 1); the user must write them only
// while no item is in flight, as the block does not enforce it.
// A new item is taken only after the last one's update, set by the
// registered read of the bin memory and its read-modify-write on one port.
// While a result waits under out_stall the next item is taken and read,
// and its update waits until the output register frees.
// Reset: configuration returns to its defaults, the window is closed,
// and a clearing pass writes zero to every bin, one a cycle, with
// in_stall held high.
module pc_sample_histogram
	import phist_pkg::*;
#(
	parameter int unsigned BIN_COUNT   = 512,
	parameter int unsigned COUNT_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  cmd_t                  command,
	input  logic [31:0]           pc_value,
	input  logic [31:0]           now_tick,
	input  logic [8:0]            bin_select,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [31:0]           bin_count,
	output logic                  sample_counted,
	output logic                  window_closed,
	output logic                  collecting_now,
	output logic [31:0]           windows_done
);

	ctrl_cmd_t  dp_cmd;
	dp_status_t dp_status;

	// controller
	phist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	// datapath
	phist_dp #(
		.BIN_COUNT   (BIN_COUNT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (dp_cmd),
		.status         (dp_status),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.command        (command),
		.pc_value       (pc_value),
		.now_tick       (now_tick),
		.bin_select     (bin_select),
		.bin_count      (bin_count),
		.sample_counted (sample_counted),
		.window_closed  (window_closed),
		.collecting_now (collecting_now),
		.windows_done   (windows_done)
	);

endmodule

### sim/tb_pc_sample_histogram.sv
// self-checking testbench for the pc sample histogram with a transaction-level predictor
`timescale 1ns / 1ps

module tb_pc_sample_histogram;
	import phist_pkg::*;

	localparam int unsigned HIST_DEPTH  = 512;
	localparam int unsigned CYCLE_LIMIT = 100000;
	// command code left unused by the block
	localparam cmd_t CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] count;
		logic        counted;
		logic        closed;
		logic        collecting;
		logic [31:0] windows;
	} hist_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	reg_idx_t              cfg_index = REG_WINDOW_LENGTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	cmd_t                  command = CMD_SAMPLE;
	logic [31:0]           pc_value = '0;
	logic [31:0]           now_tick = '0;
	logic [8:0]            bin_select = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [31:0]           bin_count;
	logic                  sample_counted;
	logic                  window_closed;
	logic                  collecting_now;
	logic [31:0]           windows_done;

	// predictor state and configuration
	logic [31:0] bin_tally [HIST_DEPTH];
	logic [31:0] stop_at = '0;
	logic        window_open = 1'b0;
	logic [31:0] restart_total = '0;
	logic [31:0] cfg_window_len = WINDOW_LENGTH_RST;
	logic [4:0]  cfg_bin_shift = BIN_SHIFT_RST;

	hist_result_t expected_results [$];
	int unsigned  mismatches = 0;
	int unsigned  cycle_count = 0;
	bit           idle_on = 1'b1;
	logic [31:0]  tick_now = '0;

	pc_sample_histogram DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// next expected result, updating the predicted histogram
	function automatic hist_result_t predict_histogram(cmd_t c, logic [31:0] pc,
			logic [31:0] now, logic [8:0] sel);
		hist_result_t r;
		logic [31:0] bin;
		r = '0;
		case (c)
			CMD_SAMPLE: begin
				if (window_open) begin
					bin = pc >> cfg_bin_shift;
					if (bin < HIST_DEPTH) begin
						bin_tally[bin[8:0]] = bin_tally[bin[8:0]] + 32'd1;
						r.counted = 1'b1;
					end
					if (now > stop_at) begin
						window_open = 1'b0;
						r.closed = 1'b1;
					end
				end
			end
			CMD_READ: begin
				r.count = bin_tally[sel];
				bin_tally[sel] = '0;
			end
			CMD_RESTART: begin
				stop_at = now + cfg_window_len;
				window_open = 1'b1;
				restart_total = restart_total + 32'd1;
			end
			default: ;
		endcase
		r.collecting = window_open;
		r.windows = restart_total;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	// result checking and receiver stalls
	always @(posedge clk) begin : result_check
		hist_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result expected none actual %0h", $time, bin_count);
			end else begin
				want = expected_results.pop_front();
				check_field("bin_count", want.count, bin_count);
				check_field("sample_counted", {31'd0, want.counted}, {31'd0, sample_counted});
				check_field("window_closed", {31'd0, want.closed}, {31'd0, window_closed});
				check_field("collecting_now", {31'd0, want.collecting}, {31'd0, collecting_now});
				check_field("windows_done", want.windows, windows_done);
			end
		end
		out_stall <= idle_on && ($urandom_range(99) < 14);
	end

	// one input transfer, with random idle cycles ahead of it
	task automatic send_item(cmd_t c, logic [31:0] pc, logic [31:0] now, logic [8:0] sel);
		while (idle_on && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		command <= c;
		pc_value <= pc;
		now_tick <= now;
		bin_select <= sel;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(predict_histogram(c, pc, now, sel));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WINDOW_LENGTH)
			cfg_window_len = value;
		else
			cfg_bin_shift = value[4:0];
	endtask

	// samples before any window is opened are ignored
	task automatic test_idle_samples();
		send_item(CMD_SAMPLE, 32'd0, 32'd0, 9'd0);
		send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd511);
		send_item(CMD_READ, 32'd0, 32'd0, 9'd0);
		send_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd511);
	endtask

	// default configuration: bin edges, window end, read and clear, restart reload
	task automatic test_window_basics();
		send_item(CMD_RESTART, 32'd0, 32'd0, 9'd0);
		send_item(CMD_SAMPLE, 32'd0, 32'd0, 9'd0);
		send_item(CMD_SAMPLE, 32'h0000_7FFF, 32'd10, 9'd0);
		// first bin past the end counts nothing
		send_item(CMD_SAMPLE, 32'h0000_8000, 32'd20, 9'd0);
		// tick equal to stop tick keeps the window open
		send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 32'd600000, 9'd0);
		send_item(CMD_SAMPLE, 32'h0000_0040, 32'd600001, 9'd0);
		send_item(CMD_SAMPLE, 32'd0, 32'd600002, 9'd0);
		send_item(CMD_READ, 32'd0, 32'd0, 9'd0);
		send_item(CMD_READ, 32'd0, 32'd0, 9'd0);
		send_item(CMD_READ, 32'd0, 32'd0, 9'd511);
		send_item(CMD_READ, 32'd0, 32'd0, 9'd1);
		send_item(CMD_RESTART, 32'd0, 32'd100, 9'd0);
		send_item(CMD_RESTART, 32'd0, 32'd200, 9'd0);
		send_item(CMD_UNUSED, 32'd0, 32'd0, 9'd0);
		// out of range sample still closes the window
		send_item(CMD_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0);
	endtask

	// register extremes and stop tick wrapping past zero
	task automatic test_tick_wrap();
		wait_drained();
		write_reg(REG_WINDOW_LENGTH, 32'hFFFF_FFFF);
		write_reg(REG_BIN_SHIFT, 32'd31);
		send_item(CMD_RESTART, 32'd0, 32'd5, 9'd0);
		send_item(CMD_SAMPLE, 32'h8000_0000, 32'd4, 9'd0);
		send_item(CMD_SAMPLE, 32'd0, 32'd5, 9'd0);
		send_item(CMD_READ, 32'd0, 32'd0, 9'd1);
		wait_drained();
		write_reg(REG_WINDOW_LENGTH, 32'd1);
		write_reg(REG_BIN_SHIFT, 32'd0);
		send_item(CMD_RESTART, 32'd0, 32'hFFFF_FFFF, 9'd0);
		send_item(CMD_SAMPLE, 32'd511, 32'd0, 9'd0);
		send_item(CMD_SAMPLE, 32'd512, 32'd1, 9'd0);
		send_item(CMD_READ, 32'd0, 32'd0, 9'd511);
	endtask

	// random traffic under one setting, mostly in-range samples on a moving tick
	task automatic test_random_traffic(int unsigned n_items, logic [31:0] win_len,
			logic [4:0] shift, bit quiet);
		logic [31:0] max_bin;
		logic [31:0] hot_max;
		logic [31:0] mask;
		logic [31:0] bin;
		logic [31:0] pc;
		logic [31:0] now;
		logic [8:0]  sel;
		cmd_t        c;
		int unsigned pick;
		wait_drained();
		write_reg(REG_WINDOW_LENGTH, win_len);
		write_reg(REG_BIN_SHIFT, {27'd0, shift});
		idle_on = !quiet;
		max_bin = 32'hFFFF_FFFF >> shift;
		if (max_bin > HIST_DEPTH - 1)
			max_bin = HIST_DEPTH - 1;
		hot_max = (max_bin < 15) ? max_bin : 32'd15;
		mask = (32'd1 << shift) - 32'd1;
		for (int unsigned i = 0; i < n_items; i++) begin
			tick_now = tick_now + $urandom_range(8);
			now = ($urandom_range(99) < 5) ? $urandom : tick_now;
			bin = ($urandom_range(99) < 60) ? $urandom_range(hot_max) : $urandom_range(max_bin);
			pc = ($urandom_range(99) < 80) ? ((bin << shift) | ($urandom & mask)) : $urandom;
			sel = ($urandom_range(99) < 70) ? 9'($urandom_range(15)) : 9'($urandom_range(511));
			pick = $urandom_range(99);
			if (pick < 60)
				c = CMD_SAMPLE;
			else if (pick < 80)
				c = CMD_READ;
			else if (pick < 95)
				c = CMD_RESTART;
			else
				c = CMD_UNUSED;
			send_item(c, pc, now, sel);
		end
		idle_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < HIST_DEPTH; i++)
			bin_tally[i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_samples();
		test_window_basics();
		test_tick_wrap();
		test_random_traffic(100, 32'd40, 5'd6, 1'b0);
		// long stretch with no idling on either side
		test_random_traffic(100, 32'd1, 5'd0, 1'b1);
		test_random_traffic(80, 32'hFFFF_FFFF, 5'd31, 1'b0);
		test_random_traffic(120, $urandom_range(300, 10), 5'($urandom_range(12)), 1'b0);
		wait_drained();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
